@@ src/sst_pkg.sv @@
// Shared types, constants and helper functions for the sprite slide tween sequencer.
// No dependencies; every other file imports this package.
`default_nettype none
package sst_pkg;

  localparam int COORD_BITS = 13;
  localparam int FRAC_BITS  = 16;
  localparam int FADE_W     = 16;
  localparam int DIR_W      = 3;
  localparam int OP_W       = 3;
  localparam int PHASE_W    = 3;
  localparam int SCREEN_W   = 12;
  localparam int HALF_W     = 11;
  localparam int HOME_W     = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // progress word holds 0 .. 1.0 inclusive
  localparam int RW = FRAC_BITS + 1;
  // signed multiplier operand covers progress and a coordinate difference
  localparam int MW = ((RW > COORD_BITS + 1) ? RW : COORD_BITS + 1) + 1;
  localparam int PW = 2 * MW;
  // working width for edge sums and blended positions before saturation
  localparam int SATW = 18;
  localparam int DIV_CNT_W = $clog2(FRAC_BITS + 1);

  localparam int IN_DATA_W  = ((2 * DIR_W + 3 * FADE_W + 7) / 8) * 8;
  localparam int OUT_BITS   = 2 * COORD_BITS + 1 + PHASE_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [FADE_W:0]       cnt_t;
  typedef logic [RW-1:0]                frac_t;
  typedef logic signed [MW-1:0]         mop_t;
  typedef logic signed [PW-1:0]         prod_t;
  typedef logic signed [SATW-1:0]       wide_t;

  localparam frac_t ONE_Q  = frac_t'(1 << FRAC_BITS);
  localparam frac_t HALF_Q = frac_t'(1 << (FRAC_BITS - 1));
  localparam wide_t CMAX   = wide_t'((1 << (COORD_BITS - 1)) - 1);
  localparam wide_t CMIN   = wide_t'(-(1 << (COORD_BITS - 1)));

  typedef enum logic [PHASE_W-1:0] {
    PH_HIDDEN  = 3'd0,
    PH_SHOWN   = 3'd1,
    PH_HOLDING = 3'd2,
    PH_FADE_IN = 3'd3,
    PH_IN_HOLD = 3'd4,
    PH_IN_OUT  = 3'd5,
    PH_FADE_OUT = 3'd6
  } phase_t;

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 3'd0,
    OP_FADE_IN  = 3'd1,
    OP_FADE_OUT = 3'd2,
    OP_IN_HOLD  = 3'd3,
    OP_IN_OUT   = 3'd4
  } op_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_UP        = 3'd0,
    DIR_DOWN      = 3'd1,
    DIR_RIGHT     = 3'd2,
    DIR_LEFT      = 3'd3,
    DIR_UP_LEFT   = 3'd4,
    DIR_DOWN_RIGHT = 3'd5
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_W = 3'd0,
    REG_SCREEN_H = 3'd1,
    REG_HOME_X   = 3'd2,
    REG_HOME_Y   = 3'd3,
    REG_HALF_W   = 3'd4,
    REG_HALF_H   = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_CUBE1,
    ST_CUBE2,
    ST_CUBE3,
    ST_BX,
    ST_BY,
    ST_BYW,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic   ok;
    coord_t x;
    coord_t y;
  } point_t;

  // clamp to the signed coordinate range
  function automatic coord_t sat_coord(input wide_t v);
    coord_t r;
    if (v > CMAX) r = CMAX[COORD_BITS-1:0];
    else if (v < CMIN) r = CMIN[COORD_BITS-1:0];
    else r = v[COORD_BITS-1:0];
    return r;
  endfunction

  // off-screen point for an edge direction; ok is low for undefined codes
  function automatic point_t edge_point(input logic [DIR_W-1:0] dir,
                                        input logic [SCREEN_W-1:0] sw,
                                        input logic [SCREEN_W-1:0] sh,
                                        input logic [HALF_W-1:0] hw,
                                        input logic [HALF_W-1:0] hh,
                                        input coord_t hx,
                                        input coord_t hy);
    wide_t  w, h, l, u, px, py;
    point_t p;
    w  = $signed(wide_t'(sw) + wide_t'(hw));
    h  = $signed(wide_t'(sh) + wide_t'(hh));
    l  = -$signed(wide_t'(hw));
    u  = -$signed(wide_t'(hh));
    px = '0;
    py = '0;
    p.ok = 1'b1;
    unique case (dir)
      DIR_UP:         begin px = wide_t'(hx); py = u; end
      DIR_DOWN:       begin px = wide_t'(hx); py = h; end
      DIR_RIGHT:      begin px = w; py = wide_t'(hy); end
      DIR_LEFT:       begin px = l; py = wide_t'(hy); end
      DIR_UP_LEFT:    begin px = l; py = u; end
      DIR_DOWN_RIGHT: begin px = w; py = h; end
      default:        p.ok = 1'b0;
    endcase
    p.x = sat_coord(px);
    p.y = sat_coord(py);
    return p;
  endfunction

endpackage
`default_nettype wire

@@ src/sst_div.sv @@
// Restoring divider, one quotient bit per cycle, for fractional fade progress.
// Depends on sst_pkg.
`default_nettype none
module sst_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [sst_pkg::FADE_W-1:0] num,
  input  wire logic [sst_pkg::FADE_W-1:0] den,
  output logic done,
  output logic [sst_pkg::FRAC_BITS-1:0] quo
);
  import sst_pkg::*;

  logic busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [FADE_W:0]   rem;
  logic [FADE_W+1:0] rem_sh;
  logic              ge;
  logic [FADE_W:0]   rem_next;

  // shift in a zero and try to subtract the divisor
  always_comb begin
    rem_sh   = {rem, 1'b0};
    ge       = rem_sh >= {2'b00, den};
    rem_next = ge ? (FADE_W+1)'(rem_sh - {2'b00, den}) : rem_sh[FADE_W:0];
  end

  // sequence the bit steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(FRAC_BITS);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, num};
      quo <= '0;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[FRAC_BITS-2:0], ge};
    end
  end

endmodule
`default_nettype wire

@@ src/sst_mul.sv @@
// Shared signed multiplier with a registered product, used for the cube and blend steps.
// Depends on sst_pkg.
`default_nettype none
module sst_mul (
  input  wire logic clk,
  input  wire sst_pkg::mop_t a,
  input  wire sst_pkg::mop_t b,
  output sst_pkg::prod_t p
);
  import sst_pkg::*;

  // register the product
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

@@ src/sprite_slide_tween_sequencer.sv @@
// Sprite slide tween sequencer: commands and frame ticks in, one position result per item.
// Depends on sst_pkg, sst_div and sst_mul.
// Commands, idle ticks and phase steps go from acceptance straight to the output register;
// a tick that moves the sprite runs the divider and then four passes through the shared
// multiplier, and skips the division when progress is exactly 0 or 1.
// One item is in work at a time; the next is taken once the result is registered.
// Reset (synchronous, rst high) returns to hidden with the default registers.
`default_nettype none
module sprite_slide_tween_sequencer (
  input  wire logic clk,
  input  wire logic rst,
  // configuration writes
  input  wire logic cfg_we,
  input  wire logic [sst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sst_pkg::CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  wire logic s_tvalid,
  output logic s_tready,
  // fade_time, fade_dir, hold_time, out_time, out_dir (low bits first), zero pad
  input  wire logic [sst_pkg::IN_DATA_W-1:0] s_tdata,
  // opcode
  input  wire logic [sst_pkg::OP_W-1:0] s_tuser,
  // output stream
  output logic m_tvalid,
  input  wire logic m_tready,
  // pos_x, pos_y, visible, phase (low bits first), zero pad
  output logic [sst_pkg::OUT_DATA_W-1:0] m_tdata
);
  import sst_pkg::*;

  // configuration registers
  logic [SCREEN_W-1:0] view_width, view_height;
  logic [HOME_W-1:0]   home_x, home_y;
  logic [HALF_W-1:0]   half_width, half_height;

  // tween state
  phase_t phase_reg;
  cnt_t   fade_left, hold_left;
  logic [FADE_W-1:0] fade_total, pending_out_time;
  logic [DIR_W-1:0]  pending_out_dir;
  coord_t from_x, from_y, to_x, to_y, cur_x, cur_y;

  // working registers
  state_t state, state_next;
  frac_t  t, u, r;
  logic   t_lo;

  // input fields
  op_t  op;
  logic [FADE_W-1:0] fade_time, hold_time, out_time;
  logic [DIR_W-1:0]  fade_dir, out_dir;
  logic s_acc;

  assign op        = op_t'(s_tuser);
  assign fade_time = s_tdata[0 +: FADE_W];
  assign fade_dir  = s_tdata[FADE_W +: DIR_W];
  assign hold_time = s_tdata[FADE_W+DIR_W +: FADE_W];
  assign out_time  = s_tdata[2*FADE_W+DIR_W +: FADE_W];
  assign out_dir   = s_tdata[3*FADE_W+DIR_W +: DIR_W];
  assign s_tready  = (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;

  // home and edge points
  coord_t hx, hy;
  point_t ep;
  logic   fading, tick_moves, hold_expire;
  logic [DIR_W-1:0] edge_dir;

  assign hx = sat_coord(wide_t'($signed(home_x)));
  assign hy = sat_coord(wide_t'($signed(home_y)));
  assign fading = (phase_reg == PH_FADE_IN) || (phase_reg == PH_IN_HOLD) ||
                  (phase_reg == PH_IN_OUT) || (phase_reg == PH_FADE_OUT);
  assign tick_moves  = (op == OP_TICK) && fading && (fade_left >= 0);
  assign hold_expire = (op == OP_TICK) && (phase_reg == PH_HOLDING) && (hold_left < 0);
  assign edge_dir = hold_expire ? pending_out_dir : fade_dir;
  assign ep = edge_point(edge_dir, view_width, view_height, half_width, half_height, hx, hy);

  // progress select and divider
  logic need_div, div_start, div_done;
  logic [FRAC_BITS-1:0] quo;
  logic [FADE_W-1:0]    div_num;

  assign need_div  = (fade_total != '0) && (fade_left > 0) &&
                     (fade_left < $signed({1'b0, fade_total}));
  assign div_num   = fade_total - fade_left[FADE_W-1:0];
  assign div_start = (state == ST_PREP) && need_div;

  sst_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (fade_total),
    .done (div_done),
    .quo  (quo)
  );

  // shared multiplier operand select
  mop_t  mul_a, mul_b;
  prod_t mul_p;
  frac_t u_now, c_val;
  logic signed [COORD_BITS:0] dx, dy;
  prod_t pr;
  wide_t blend_pos;

  assign u_now = (t < HALF_Q) ? frac_t'(t << 1) : frac_t'((ONE_Q - t) << 1);
  assign c_val = mul_p[FRAC_BITS +: RW];
  assign dx = {to_x[COORD_BITS-1], to_x} - {from_x[COORD_BITS-1], from_x};
  assign dy = {to_y[COORD_BITS-1], to_y} - {from_y[COORD_BITS-1], from_y};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_CUBE1: begin mul_a = $signed(MW'(u_now)); mul_b = $signed(MW'(u_now)); end
      ST_CUBE2: begin mul_a = $signed(MW'(c_val)); mul_b = $signed(MW'(u)); end
      ST_BX:    begin mul_a = MW'(dx); mul_b = $signed(MW'(r)); end
      ST_BY:    begin mul_a = MW'(dy); mul_b = $signed(MW'(r)); end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  sst_mul u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (mul_p)
  );

  // round half up with floor shift, then add the start point
  assign pr = mul_p + prod_t'(HALF_Q);
  always_comb begin
    if (state == ST_BY) blend_pos = $signed(pr[FRAC_BITS +: SATW]) + wide_t'(from_x);
    else blend_pos = $signed(pr[FRAC_BITS +: SATW]) + wide_t'(from_y);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_acc) state_next = tick_moves ? ST_PREP : ST_OUT;
      ST_PREP:  state_next = need_div ? ST_DIV : ST_CUBE1;
      ST_DIV:   if (div_done) state_next = ST_CUBE1;
      ST_CUBE1: state_next = ST_CUBE2;
      ST_CUBE2: state_next = ST_CUBE3;
      ST_CUBE3: state_next = ST_BX;
      ST_BX:    state_next = ST_BY;
      ST_BY:    state_next = ST_BYW;
      ST_BYW:   state_next = ST_OUT;
      ST_OUT:   if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      view_width  <= SCREEN_W'(1280);
      view_height <= SCREEN_W'(720);
      home_x      <= '0;
      home_y      <= '0;
      half_width  <= '0;
      half_height <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCREEN_W: view_width  <= cfg_data[SCREEN_W-1:0];
        REG_SCREEN_H: view_height <= cfg_data[SCREEN_W-1:0];
        REG_HOME_X:   home_x      <= cfg_data[HOME_W-1:0];
        REG_HOME_Y:   home_y      <= cfg_data[HOME_W-1:0];
        REG_HALF_W:   half_width  <= cfg_data[HALF_W-1:0];
        REG_HALF_H:   half_height <= cfg_data[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // tween state and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg        <= PH_HIDDEN;
      fade_left        <= '0;
      fade_total       <= '0;
      hold_left        <= '0;
      pending_out_time <= '0;
      pending_out_dir  <= DIR_UP;
      from_x <= '0;
      from_y <= '0;
      to_x   <= '0;
      to_y   <= '0;
      cur_x  <= '0;
      cur_y  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (s_acc) begin
          unique case (op)
            OP_TICK: begin
              if (phase_reg == PH_HOLDING) begin
                if (hold_left < 0) begin
                  hold_left <= '0;
                  if (pending_out_time != '0) begin
                    // chained fade-out from home
                    phase_reg  <= PH_FADE_OUT;
                    from_x     <= hx;
                    from_y     <= hy;
                    cur_x      <= hx;
                    cur_y      <= hy;
                    if (ep.ok) begin
                      to_x <= ep.x;
                      to_y <= ep.y;
                    end
                    fade_left  <= cnt_t'({1'b0, pending_out_time});
                    fade_total <= pending_out_time;
                    pending_out_time <= '0;
                  end else begin
                    phase_reg <= PH_HIDDEN;
                  end
                end else begin
                  hold_left <= hold_left - cnt_t'(1);
                end
              end else if (fading) begin
                if (fade_left < 0) begin
                  fade_left <= '0;
                  unique case (phase_reg)
                    PH_FADE_IN: phase_reg <= PH_SHOWN;
                    PH_FADE_OUT: phase_reg <= PH_HIDDEN;
                    default:    phase_reg <= PH_HOLDING;
                  endcase
                end else begin
                  fade_left <= fade_left - cnt_t'(1);
                end
              end
            end
            OP_FADE_OUT: begin
              phase_reg <= PH_FADE_OUT;
              from_x <= hx;
              from_y <= hy;
              cur_x  <= hx;
              cur_y  <= hy;
              if (ep.ok) begin
                to_x <= ep.x;
                to_y <= ep.y;
              end
              fade_left  <= cnt_t'({1'b0, fade_time});
              fade_total <= fade_time;
            end
            OP_FADE_IN, OP_IN_HOLD, OP_IN_OUT: begin
              to_x <= hx;
              to_y <= hy;
              if (ep.ok) begin
                from_x <= ep.x;
                from_y <= ep.y;
                cur_x  <= ep.x;
                cur_y  <= ep.y;
              end else begin
                cur_x <= from_x;
                cur_y <= from_y;
              end
              fade_left  <= cnt_t'({1'b0, fade_time});
              fade_total <= fade_time;
              if (op == OP_FADE_IN) begin
                phase_reg <= PH_FADE_IN;
              end else begin
                hold_left <= cnt_t'({1'b0, hold_time});
                if (op == OP_IN_HOLD) begin
                  phase_reg <= PH_IN_HOLD;
                end else begin
                  phase_reg        <= PH_IN_OUT;
                  pending_out_time <= out_time;
                  pending_out_dir  <= out_dir;
                end
              end
            end
            default: ;
          endcase
        end
        ST_BY:  cur_x <= sat_coord(blend_pos);
        ST_BYW: cur_y <= sat_coord(blend_pos);
        default: ;
      endcase
    end
  end

  // progress and easing registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_PREP: begin
        if ((fade_total == '0) || (fade_left <= 0)) t <= ONE_Q;
        else t <= '0;
      end
      ST_DIV: if (div_done) t <= frac_t'(quo);
      ST_CUBE1: begin
        u    <= u_now;
        t_lo <= (t < HALF_Q);
      end
      ST_CUBE3: r <= t_lo ? frac_t'(c_val >> 1) : frac_t'(ONE_Q - (c_val >> 1));
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= OUT_DATA_W'({phase_reg, (phase_reg != PH_HIDDEN), cur_y, cur_x});
    end
  end

endmodule
`default_nettype wire

@@ src/sst_check.sv @@
// Port-level checks for the sprite slide tween sequencer, bound to the top level.
// Depends on sst_pkg and sprite_slide_tween_sequencer.
`default_nettype none
module sst_check (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  input wire logic s_tready,
  input wire logic m_tvalid,
  input wire logic m_tready,
  input wire logic [sst_pkg::OUT_DATA_W-1:0] m_tdata
);
  import sst_pkg::*;

  localparam int VIS = 2 * COORD_BITS;
  localparam int PH  = 2 * COORD_BITS + 1;

  // one item in work: no new transaction right after one is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while previous item still in work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

  // visibility follows the phase
  a_visible: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[VIS] == (m_tdata[PH +: PHASE_W] != PH_HIDDEN)))
    else $error("visible flag disagrees with phase");

  // result never appears without a prior taken item while idle and empty
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid && s_tready && !(s_tvalid && s_tready)) |=> !m_tvalid)
    else $error("result without an input item");

endmodule

bind sprite_slide_tween_sequencer sst_check u_sst_check (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
`default_nettype wire
